@@ hw/rtl/swm_pkg.sv @@
// Shared types and constants for the sliding window median filter.
// No dependencies; imported by every module of the block.
package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_BITS        = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PACK,
    ST_INSERT,
    ST_SEND
  } state_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_AGE,
    OP_PACK,
    OP_INSERT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic restart;
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      in_stall;
    logic      load_out;
  } ctl_t;

endpackage

@@ hw/rtl/swm_cell.sv @@
// One cell of the sorted sample chain: a value, its age and a valid bit.
// Depends on swm_pkg; trades contents with its lower and upper neighbors.
module swm_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_BITS    = 6,
  parameter int WB          = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_pkg::cell_cmd_t            cmd,
  input  logic [WB-1:0]                 eff_w,
  input  logic signed [SAMPLE_BITS-1:0] new_sample,
  input  logic                          dn_valid,
  input  logic signed [SAMPLE_BITS-1:0] dn_value,
  input  logic [AGE_BITS-1:0]           dn_age,
  input  logic                          dn_gt,
  input  logic                          up_valid,
  input  logic signed [SAMPLE_BITS-1:0] up_value,
  input  logic [AGE_BITS-1:0]           up_age,
  output logic                          valid,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [AGE_BITS-1:0]           age,
  output logic                          gt,
  output logic                          move
);
  import swm_pkg::*;

  logic                          valid_next;
  logic signed [SAMPLE_BITS-1:0] value_next;
  logic [AGE_BITS-1:0]           age_next;
  logic [WB-1:0]                 age_inc;

  // New sample sorts below this entry; an empty slot pulls from above
  assign gt      = valid && (new_sample < value);
  assign move    = !valid && up_valid;
  assign age_inc = WB'(age) + WB'(1);

  always_comb begin
    valid_next = valid;
    value_next = value;
    age_next   = age;
    case (cmd.op)
      OP_AGE: begin
        // Grow the age, drop the entry once it falls out of the window or on restart
        age_next = AGE_BITS'(age_inc);
        if (cmd.restart || (age_inc >= eff_w)) begin
          valid_next = 1'b0;
        end
      end
      OP_PACK: begin
        // Close holes: pull the upper entry down one place
        if (move) begin
          valid_next = 1'b1;
          value_next = up_value;
          age_next   = up_age;
        end else if (valid && !dn_valid) begin
          valid_next = 1'b0;
        end
      end
      OP_INSERT: begin
        // Shift up above the insertion point, take the new sample at it
        if (dn_gt) begin
          valid_next = 1'b1;
          value_next = dn_value;
          age_next   = dn_age;
        end else if (gt || (!valid && dn_valid)) begin
          valid_next = 1'b1;
          value_next = new_sample;
          age_next   = '0;
        end
      end
      default: begin
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    age   <= age_next;
  end

endmodule

@@ hw/rtl/swm_ctrl.sv @@
// Sequencer for the median filter: steps the cell chain through age,
// compaction and insertion, and tracks the fill count. Depends on swm_pkg.
module swm_ctrl #(
  parameter int WB = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          restart,
  input  logic [WB-1:0] eff_w,
  input  logic          any_move,
  input  logic          out_valid,
  input  logic          out_stall,
  output swm_pkg::ctl_t ctl
);
  import swm_pkg::*;

  state_t        state;
  state_t        state_next;
  logic [WB-1:0] fill;
  logic [WB-1:0] fill_next;
  logic [WB-1:0] kept;
  logic          has_result;
  logic          accept;
  logic          out_free;

  assign accept   = (state == ST_IDLE) && in_valid;
  assign out_free = !out_valid || !out_stall;

  // Entries left after aging are the youngest min(fill, w-1), none on restart
  always_comb begin
    if (restart) begin
      kept = '0;
    end else if (fill < eff_w) begin
      kept = fill;
    end else begin
      kept = eff_w - WB'(1);
    end
    fill_next = kept + WB'(1);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PACK;
      end
      ST_PACK: begin
        if (!any_move) state_next = ST_INSERT;
      end
      ST_INSERT: begin
        state_next = has_result ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctl.cmd.restart = restart;
    ctl.in_stall    = (state != ST_IDLE);
    ctl.load_out    = 1'b0;
    case (state)
      ST_IDLE:   ctl.cmd.op = in_valid ? OP_AGE : OP_HOLD;
      ST_PACK:   ctl.cmd.op = OP_PACK;
      ST_INSERT: ctl.cmd.op = OP_INSERT;
      ST_SEND: begin
        ctl.cmd.op   = OP_HOLD;
        ctl.load_out = out_free;
      end
      default:   ctl.cmd.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      has_result <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill       <= fill_next;
        has_result <= (fill_next == eff_w);
      end
    end
  end

endmodule

@@ hw/rtl/sliding_window_median.sv @@
// Sliding window median filter. Each item carries a signed sample; the block keeps the last
// window_size samples sorted in a chain of cells, each tagged with its age, and once the window
// is full every item returns twice the median (sum of the two middle values for an even window,
// twice the middle value for an odd one) on median_twice. restart empties the window before its
// sample enters; it takes effect at once, there is no clearing pass after reset. window_size 0
// acts as 1 and values above MAX_WINDOW act as MAX_WINDOW. One item at a time is in work: an
// item is aged, then compacted while a vacated slot still moves up the chain one place per cycle,
// then inserted, and when it yields a result it loads the output register, waiting there while
// out_stall holds a pending result. After window_size is lowered, vacated slots of the first item
// may have to move across the whole chain of MAX_WINDOW cells.
// Depends on swm_pkg, swm_cell and swm_ctrl.
module sliding_window_median #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS:0]     median_twice,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swm_pkg::CFG_BITS-1:0]    window_size
);
  import swm_pkg::*;

  localparam int IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WB       = $clog2(MAX_WINDOW + 1) > 0 ? $clog2(MAX_WINDOW + 1) : 1;

  logic [CFG_BITS-1:0]           window_len;
  logic [WB-1:0]                 eff_w;
  logic signed [SAMPLE_BITS-1:0] sample_reg;
  ctl_t                          ctl;
  logic                          any_move;

  logic [MAX_WINDOW-1:0]         c_valid;
  logic [MAX_WINDOW-1:0]         c_gt;
  logic [MAX_WINDOW-1:0]         c_move;
  logic signed [SAMPLE_BITS-1:0] c_value [MAX_WINDOW];
  logic [IDX_BITS-1:0]           c_age   [MAX_WINDOW];

  logic [IDX_BITS-1:0]           idx_hi;
  logic [IDX_BITS-1:0]           idx_lo;
  logic signed [SAMPLE_BITS-1:0] lo_val;
  logic signed [SAMPLE_BITS-1:0] hi_val;
  logic signed [SAMPLE_BITS:0]   median_next;

  // Window size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
    end else if (cfg_valid) begin
      window_len <= window_size;
    end
  end

  // Clamp the window size to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      eff_w = WB'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      eff_w = WB'(MAX_WINDOW);
    end else begin
      eff_w = WB'(window_len);
    end
  end

  // Hold the sample until it is inserted
  always_ff @(posedge clk) begin
    if (!ctl.in_stall && in_valid) begin
      sample_reg <= sample;
    end
  end

  assign in_stall = ctl.in_stall;
  assign any_move = |c_move;

  swm_ctrl #(
    .WB(WB)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .restart   (restart),
    .eff_w     (eff_w),
    .any_move  (any_move),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Chain of cells, lowest value at index 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                          dn_valid;
    logic signed [SAMPLE_BITS-1:0] dn_value;
    logic [IDX_BITS-1:0]           dn_age;
    logic                          dn_gt;
    logic                          up_valid;
    logic signed [SAMPLE_BITS-1:0] up_value;
    logic [IDX_BITS-1:0]           up_age;

    if (i == 0) begin : g_bottom
      assign dn_valid = 1'b1;
      assign dn_value = '0;
      assign dn_age   = '0;
      assign dn_gt    = 1'b0;
    end else begin : g_dn
      assign dn_valid = c_valid[i-1];
      assign dn_value = c_value[i-1];
      assign dn_age   = c_age[i-1];
      assign dn_gt    = c_gt[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_value = '0;
      assign up_age   = '0;
    end else begin : g_up
      assign up_valid = c_valid[i+1];
      assign up_value = c_value[i+1];
      assign up_age   = c_age[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .AGE_BITS   (IDX_BITS),
      .WB         (WB)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (ctl.cmd),
      .eff_w      (eff_w),
      .new_sample (sample_reg),
      .dn_valid   (dn_valid),
      .dn_value   (dn_value),
      .dn_age     (dn_age),
      .dn_gt      (dn_gt),
      .up_valid   (up_valid),
      .up_value   (up_value),
      .up_age     (up_age),
      .valid      (c_valid[i]),
      .value      (c_value[i]),
      .age        (c_age[i]),
      .gt         (c_gt[i]),
      .move       (c_move[i])
    );
  end

  // Pick the middle entries and add them
  always_comb begin
    idx_hi = IDX_BITS'(eff_w >> 1);
    idx_lo = eff_w[0] ? idx_hi : (idx_hi - IDX_BITS'(1));
    lo_val = c_value[idx_lo];
    hi_val = c_value[idx_hi];
    median_next = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      median_twice <= median_next;
    end
  end

endmodule

@@ hw/rtl/swm_checker.sv @@
// Port-level checks for the sliding window median filter, bound to the top level.
// Depends on swm_pkg and sees only the ports of sliding_window_median.
module swm_checker #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS:0]   median_twice,
  input logic [swm_pkg::CFG_BITS-1:0]  window_size
);
  import swm_pkg::*;

  // An accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted item");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(median_twice)))
    else $error("stalled result changed or dropped");

  // An odd window gives twice one sample, so the fraction bit is clear
  a_odd_even: assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_size[0] && (32'(window_size) <= 32'(MAX_WINDOW)))
      |-> !median_twice[0])
    else $error("odd window produced a half-valued median");

  // A one-sample window echoes the sample doubled
  a_window_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid && (window_size == 7'd1))
      |-> ##4 (out_valid && (median_twice == {$past(sample, 4), 1'b0})))
    else $error("window of one did not return the doubled sample");

endmodule

bind sliding_window_median swm_checker #(
  .MAX_WINDOW (MAX_WINDOW),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_swm_checker (.*);
